>>> hdl/chunked_copy_completion_tracker_unit_defines.svh
// assertion macros used by the tracker back end
// expects signals named clock and reset in the including module
`ifndef CHUNKED_COPY_COMPLETION_TRACKER_UNIT_DEFINES_SVH
`define CHUNKED_COPY_COMPLETION_TRACKER_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define CCCT_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// implication checked in the same cycle outside reset
`define CCCT_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hdl/ccct_pkg.sv
// shared widths, codes and job record for the chunked copy completion tracker
// no dependencies
package ccct_pkg;

   localparam int ADDR_W   = 48;
   localparam int SEQ_W    = 48;
   localparam int BYTES_W  = 31;
   localparam int LEN_W    = 25;
   localparam int LOG2_W   = 5;
   localparam int KIND_W   = 3;
   localparam int TYPE_W   = 2;

   // chunk size limits, log2 of bytes
   localparam logic [LOG2_W-1:0] CHUNK_LOG2_MIN   = 5'd12;
   localparam logic [LOG2_W-1:0] CHUNK_LOG2_MAX   = 5'd24;
   localparam logic [LOG2_W-1:0] CHUNK_LOG2_RESET = 5'd20;

   // width of the chunk count of the largest copy at the smallest chunk size
   localparam int CHUNKS_W = BYTES_W - 12 + 1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_FINISH  = 2'd1,
      REQ_WAIT    = 2'd2
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      RK_DESC   = 3'd0,
      RK_ANSWER = 3'd1,
      RK_SIGNAL = 3'd2,
      RK_ACK    = 3'd3,
      RK_ERROR  = 3'd4
   } result_kind_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_COPY       = 3'd0,
      OP_EMPTY_COPY = 3'd1,
      OP_OVERSIZE   = 3'd2,
      OP_FINISH     = 3'd3,
      OP_WAIT       = 3'd4,
      OP_BAD        = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   source;
      logic [ADDR_W-1:0]   dest;
      logic [BYTES_W-1:0]  bytes;
      logic [SEQ_W-1:0]    seq;
      logic [LOG2_W-1:0]   chunk_log2;
   } job_type;

endpackage

>>> hdl/ccct_channels.sv
// request and result channel interfaces of the tracker
// depends on ccct_pkg
interface ccct_req_if;
   import ccct_pkg::*;

   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [ADDR_W-1:0]   source_address;
   logic [ADDR_W-1:0]   dest_address;
   logic [BYTES_W-1:0]  copy_bytes;
   logic [SEQ_W-1:0]    seq_number;

   modport source (
      output valid, req_type, source_address, dest_address, copy_bytes, seq_number,
      input  ready
   );
   modport sink (
      input  valid, req_type, source_address, dest_address, copy_bytes, seq_number,
      output ready
   );
endinterface

interface ccct_rsp_if;
   import ccct_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [ADDR_W-1:0]   chunk_source;
   logic [ADDR_W-1:0]   chunk_dest;
   logic [LEN_W-1:0]    chunk_length;
   logic [SEQ_W-1:0]    chunk_seq;
   logic                already_done;
   logic [SEQ_W-1:0]    done_mark;
   logic                last_of_run;

   modport source (
      output valid, result_kind, chunk_source, chunk_dest, chunk_length, chunk_seq,
             already_done, done_mark, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, result_kind, chunk_source, chunk_dest, chunk_length, chunk_seq,
             already_done, done_mark, last_of_run,
      output ready
   );
endinterface

>>> hdl/ccct_front.sv
// front end: accepts request transfers, holds the chunk size register, classifies jobs
// depends on ccct_pkg and ccct_req_if
module ccct_front #(
   parameter int MAX_CHUNKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ccct_pkg::LOG2_W-1:0]   csr_wr_data,
   ccct_req_if.sink                      req_bus,
   output ccct_pkg::job_type             job_data,
   output logic                          job_valid,
   input  logic                          job_ready
);
   import ccct_pkg::*;

   logic [LOG2_W-1:0]   chunk_log2_ff, chunk_log2_in;
   logic [LOG2_W-1:0]   log2_sat;
   logic [BYTES_W-1:0]  frac_mask;
   logic [BYTES_W-1:0]  whole_chunks;
   logic [CHUNKS_W-1:0] chunk_count;
   logic                too_many;

   // chunk size register
   assign chunk_log2_in = csr_wr_en ? csr_wr_data : chunk_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_log2_ff <= CHUNK_LOG2_RESET;
      end else begin
         chunk_log2_ff <= chunk_log2_in;
      end
   end

   // saturated chunk size and chunk count of the copy
   always_comb begin
      if (chunk_log2_ff < CHUNK_LOG2_MIN) begin
         log2_sat = CHUNK_LOG2_MIN;
      end else if (chunk_log2_ff > CHUNK_LOG2_MAX) begin
         log2_sat = CHUNK_LOG2_MAX;
      end else begin
         log2_sat = chunk_log2_ff;
      end
      frac_mask    = (BYTES_W'(1) << log2_sat) - BYTES_W'(1);
      whole_chunks = req_bus.copy_bytes >> log2_sat;
      chunk_count  = CHUNKS_W'(whole_chunks)
                   + CHUNKS_W'(|(req_bus.copy_bytes & frac_mask));
      too_many     = chunk_count > CHUNKS_W'(MAX_CHUNKS);
   end

   // classify the transfer into a job record
   always_comb begin
      job_data.source     = req_bus.source_address;
      job_data.dest       = req_bus.dest_address;
      job_data.bytes      = req_bus.copy_bytes;
      job_data.seq        = req_bus.seq_number;
      job_data.chunk_log2 = log2_sat;
      case (req_bus.req_type)
         REQ_ENQUEUE: begin
            if (req_bus.copy_bytes == '0) begin
               job_data.op = OP_EMPTY_COPY;
            end else if (too_many) begin
               job_data.op = OP_OVERSIZE;
            end else begin
               job_data.op = OP_COPY;
            end
         end
         REQ_FINISH: job_data.op = OP_FINISH;
         REQ_WAIT:   job_data.op = OP_WAIT;
         default:    job_data.op = OP_BAD;
      endcase
   end

   // handshake straight into the job queue
   assign job_valid     = req_bus.valid;
   assign req_bus.ready = job_ready;

endmodule

>>> hdl/ccct_fifo.sv
// two-entry job queue between the front end and the execution back end
// depends on ccct_pkg
module ccct_fifo (
   input  logic                clock,
   input  logic                reset,
   input  ccct_pkg::job_type   in_data,
   input  logic                in_valid,
   output logic                in_ready,
   output ccct_pkg::job_type   out_data,
   output logic                out_valid,
   input  logic                out_ready
);
   import ccct_pkg::*;

   localparam int DEPTH = 2;
   localparam int CNT_W = 2;

   job_type             slot_ff [DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   // pointer and fill bookkeeping
   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> hdl/ccct_back.sv
// back end: runs jobs against the tracker state and drives the result register
// depends on ccct_pkg, ccct_rsp_if and the assertion macro header
`include "chunked_copy_completion_tracker_unit_defines.svh"

module ccct_back #(
   parameter int EARLY_WINDOW  = 64,
   parameter int REQUEST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ccct_pkg::job_type   job_data,
   input  logic                job_valid,
   output logic                job_ready,
   ccct_rsp_if.source          rsp_bus
);
   import ccct_pkg::*;

   localparam int SLOT_W = (EARLY_WINDOW > 1) ? $clog2(EARLY_WINDOW) : 1;
   localparam int QI_W   = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
   localparam int QC_W   = $clog2(REQUEST_DEPTH + 1);
   localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W+1)'(EARLY_WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(EARLY_WINDOW - 1);
   localparam logic [QI_W-1:0]   QI_LAST   = QI_W'(REQUEST_DEPTH - 1);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_COPY      = 6'b000010,
      ST_SWEEP     = 6'b000100,
      ST_DRAIN_RD  = 6'b001000,
      ST_DRAIN_CMP = 6'b010000,
      ST_REPORT    = 6'b100000
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic [SEQ_W-1:0]          next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]          mark_ff, mark_in;
   logic [SLOT_W-1:0]         mark_slot_ff, mark_slot_in;
   logic [SEQ_W-1:0]          last_sig_ff, last_sig_in;
   logic [EARLY_WINDOW-1:0]   early_ff, early_in;
   logic [QI_W-1:0]           tq_head_ff, tq_head_in;
   logic [QI_W-1:0]           tq_tail_ff, tq_tail_in;
   logic [QC_W-1:0]           tq_count_ff, tq_count_in;
   logic                      drained_ff, drained_in;

   // copy walk and threshold payload
   logic [ADDR_W-1:0]         src_ff, src_in;
   logic [ADDR_W-1:0]         dst_ff, dst_in;
   logic [BYTES_W-1:0]        remain_ff, remain_in;
   logic [LOG2_W-1:0]         chunk_log2_ff, chunk_log2_in;
   logic [SEQ_W-1:0]          tq_back_ff, tq_back_in;
   logic [SEQ_W-1:0]          tq_rdata_ff;
   logic [SEQ_W-1:0]          tq_mem [REQUEST_DEPTH];
   logic                      tq_we;

   // result register
   logic                      out_valid_ff, out_valid_in;
   result_kind_type           out_kind_ff, out_kind_in;
   logic [ADDR_W-1:0]         out_src_ff, out_src_in;
   logic [ADDR_W-1:0]         out_dst_ff, out_dst_in;
   logic [LEN_W-1:0]          out_len_ff, out_len_in;
   logic [SEQ_W-1:0]          out_seq_ff, out_seq_in;
   logic                      out_done_ff, out_done_in;
   logic [SEQ_W-1:0]          out_mark_ff, out_mark_in;
   logic                      out_last_ff, out_last_in;

   // per-cycle helpers
   logic                      out_free;
   logic                      job_pop;
   logic [LEN_W-1:0]          chunk_size;
   logic [BYTES_W-1:0]        chunk_wide;
   logic [SEQ_W-1:0]          fin_gap;
   logic                      seq_wrapped;
   logic [SLOT_W:0]           slot_sum;
   logic [SLOT_W-1:0]         slot_set;
   logic [SEQ_W-1:0]          adv_mark;
   logic [SLOT_W-1:0]         adv_slot;
   logic                      req_met, req_dup, req_full;

   logic                      emit;
   result_kind_type           e_kind;
   logic [ADDR_W-1:0]         e_src, e_dst;
   logic [LEN_W-1:0]          e_len;
   logic [SEQ_W-1:0]          e_seq, e_mark;
   logic                      e_done, e_last;

   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign job_pop    = (state_ff == ST_IDLE) && job_valid && out_free;
   assign job_ready  = job_pop;
   assign chunk_size = LEN_W'(1) << chunk_log2_ff;
   assign chunk_wide = BYTES_W'(chunk_size);

   // distance of a finished chunk from the mark and its bitmap slot
   always_comb begin
      fin_gap     = job_data.seq - mark_ff;
      seq_wrapped = job_data.seq < mark_ff;
      slot_sum    = {1'b0, mark_slot_ff} + {1'b0, fin_gap[SLOT_W-1:0]};
      if (seq_wrapped) begin
         slot_set = job_data.seq[SLOT_W-1:0];
      end else if (slot_sum >= WIN_EXT) begin
         slot_set = SLOT_W'(slot_sum - WIN_EXT);
      end else begin
         slot_set = slot_sum[SLOT_W-1:0];
      end
   end

   // mark plus one, slot follows with wrap at the window and at the 48-bit end
   always_comb begin
      adv_mark = mark_ff + 1'b1;
      if (&mark_ff) begin
         adv_slot = '0;
      end else if (mark_slot_ff == SLOT_LAST) begin
         adv_slot = '0;
      end else begin
         adv_slot = mark_slot_ff + 1'b1;
      end
   end

   // threshold request tests
   assign req_met  = mark_ff >= job_data.seq;
   assign req_dup  = (tq_count_ff != '0) && (tq_back_ff >= job_data.seq);
   assign req_full = tq_count_ff == QC_W'(REQUEST_DEPTH);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      next_seq_in   = next_seq_ff;
      mark_in       = mark_ff;
      mark_slot_in  = mark_slot_ff;
      last_sig_in   = last_sig_ff;
      early_in      = early_ff;
      tq_head_in    = tq_head_ff;
      tq_tail_in    = tq_tail_ff;
      tq_count_in   = tq_count_ff;
      drained_in    = drained_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      remain_in     = remain_ff;
      chunk_log2_in = chunk_log2_ff;
      tq_back_in    = tq_back_ff;
      tq_we         = 1'b0;

      emit   = 1'b0;
      e_kind = RK_ACK;
      e_src  = '0;
      e_dst  = '0;
      e_len  = '0;
      e_seq  = '0;
      e_done = 1'b0;
      e_mark = mark_ff;
      e_last = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               case (job_data.op)
                  OP_COPY: begin
                     src_in        = job_data.source;
                     dst_in        = job_data.dest;
                     remain_in     = job_data.bytes;
                     chunk_log2_in = job_data.chunk_log2;
                     state_in      = ST_COPY;
                  end
                  OP_EMPTY_COPY: begin
                     emit   = 1'b1;
                     e_kind = RK_ACK;
                  end
                  OP_FINISH: begin
                     if (fin_gap == '0) begin
                        mark_in      = adv_mark;
                        mark_slot_in = adv_slot;
                        drained_in   = 1'b0;
                        state_in     = ST_SWEEP;
                     end else if (fin_gap < SEQ_W'(EARLY_WINDOW)) begin
                        early_in[slot_set] = 1'b1;
                        emit   = 1'b1;
                        e_kind = RK_ACK;
                     end else begin
                        emit   = 1'b1;
                        e_kind = RK_ERROR;
                     end
                  end
                  OP_WAIT: begin
                     emit = 1'b1;
                     if (req_met) begin
                        e_kind = RK_ANSWER;
                        e_done = 1'b1;
                     end else if (req_dup) begin
                        e_kind = RK_ANSWER;
                     end else if (req_full) begin
                        e_kind = RK_ERROR;
                     end else begin
                        tq_we       = 1'b1;
                        tq_tail_in  = (tq_tail_ff == QI_LAST) ? '0 : tq_tail_ff + 1'b1;
                        tq_count_in = tq_count_ff + 1'b1;
                        tq_back_in  = job_data.seq;
                        e_kind      = RK_ANSWER;
                     end
                  end
                  default: begin
                     emit   = 1'b1;
                     e_kind = RK_ERROR;
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (out_free) begin
               emit        = 1'b1;
               e_kind      = RK_DESC;
               e_src       = src_ff;
               e_dst       = dst_ff;
               e_len       = (remain_ff > chunk_wide) ? chunk_size : LEN_W'(remain_ff);
               e_seq       = next_seq_ff;
               e_mark      = '0;
               e_last      = remain_ff <= chunk_wide;
               next_seq_in = next_seq_ff + 1'b1;
               src_in      = src_ff + ADDR_W'(chunk_size);
               dst_in      = dst_ff + ADDR_W'(chunk_size);
               remain_in   = remain_ff - chunk_wide;
               if (remain_ff <= chunk_wide) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            if (early_ff[mark_slot_ff]) begin
               early_in[mark_slot_ff] = 1'b0;
               mark_in      = adv_mark;
               mark_slot_in = adv_slot;
            end else begin
               state_in = ST_DRAIN_RD;
            end
         end
         ST_DRAIN_RD: begin
            state_in = (tq_count_ff == '0) ? ST_REPORT : ST_DRAIN_CMP;
         end
         ST_DRAIN_CMP: begin
            if (tq_rdata_ff <= mark_ff) begin
               tq_head_in  = (tq_head_ff == QI_LAST) ? '0 : tq_head_ff + 1'b1;
               tq_count_in = tq_count_ff - 1'b1;
               drained_in  = 1'b1;
               state_in    = ST_DRAIN_RD;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               emit = 1'b1;
               if (drained_ff && (mark_ff > last_sig_ff)) begin
                  e_kind      = RK_SIGNAL;
                  last_sig_in = mark_ff;
               end else begin
                  e_kind = RK_ACK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register load
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_kind_in  = out_kind_ff;
      out_src_in   = out_src_ff;
      out_dst_in   = out_dst_ff;
      out_len_in   = out_len_ff;
      out_seq_in   = out_seq_ff;
      out_done_in  = out_done_ff;
      out_mark_in  = out_mark_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = e_kind;
         out_src_in   = e_src;
         out_dst_in   = e_dst;
         out_len_in   = e_len;
         out_seq_in   = e_seq;
         out_done_in  = e_done;
         out_mark_in  = e_mark;
         out_last_in  = e_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_seq_ff  <= '0;
         mark_ff      <= '0;
         mark_slot_ff <= '0;
         last_sig_ff  <= '0;
         early_ff     <= '0;
         tq_head_ff   <= '0;
         tq_tail_ff   <= '0;
         tq_count_ff  <= '0;
         drained_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_seq_ff  <= next_seq_in;
         mark_ff      <= mark_in;
         mark_slot_ff <= mark_slot_in;
         last_sig_ff  <= last_sig_in;
         early_ff     <= early_in;
         tq_head_ff   <= tq_head_in;
         tq_tail_ff   <= tq_tail_in;
         tq_count_ff  <= tq_count_in;
         drained_ff   <= drained_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      remain_ff     <= remain_in;
      chunk_log2_ff <= chunk_log2_in;
      tq_back_ff    <= tq_back_in;
      out_kind_ff   <= out_kind_in;
      out_src_ff    <= out_src_in;
      out_dst_ff    <= out_dst_in;
      out_len_ff    <= out_len_in;
      out_seq_ff    <= out_seq_in;
      out_done_ff   <= out_done_in;
      out_mark_ff   <= out_mark_in;
      out_last_ff   <= out_last_in;
   end

   // threshold ring memory, registered read at the head
   always_ff @(posedge clock) begin
      if (tq_we) begin
         tq_mem[tq_tail_ff] <= job_data.seq;
      end
      tq_rdata_ff <= tq_mem[tq_head_ff];
   end

   // result channel
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.result_kind  = out_kind_ff;
   assign rsp_bus.chunk_source = out_src_ff;
   assign rsp_bus.chunk_dest   = out_dst_ff;
   assign rsp_bus.chunk_length = out_len_ff;
   assign rsp_bus.chunk_seq    = out_seq_ff;
   assign rsp_bus.already_done = out_done_ff;
   assign rsp_bus.done_mark    = out_mark_ff;
   assign rsp_bus.last_of_run  = out_last_ff;

   // checks
   `CCCT_ASSERT(a_queue_bound, tq_count_ff <= QC_W'(REQUEST_DEPTH), "threshold queue overfilled")
   `CCCT_ASSERT_IMPL(a_mark_slot_clear, state_ff == ST_IDLE, !early_ff[mark_slot_ff], "early bit set at mark")
   `CCCT_ASSERT_IMPL(a_drain_nonempty, state_ff == ST_DRAIN_CMP, tq_count_ff != '0, "drain compare on empty queue")
   `CCCT_ASSERT_IMPL(a_copy_remaining, state_ff == ST_COPY, remain_ff != '0, "copy walk with no bytes left")

endmodule

>>> hdl/chunked_copy_completion_tracker_unit.sv
// top level of the chunked copy completion tracker
// depends on ccct_pkg, ccct_channels, ccct_front, ccct_fifo and ccct_back
//
// Usage:
//   req_bus carries one operation per transfer: enqueue a copy, report a chunk
//   finished, or wait for a sequence threshold. rsp_bus returns results; the
//   last result of each operation has last_of_run set. csr_wr_en/csr_wr_data
//   write the log2 chunk size; the user must write it only while the block is
//   idle, which the block itself does not enforce.
// Flow:
//   a transfer enters a two-entry job queue; the back end takes it from the
//   queue and loads its first result into the result register on rsp_bus.
//   A copy holds the back end while it emits one descriptor per cycle, as
//   long as rsp_bus is not stalled; plain completions and requests give a
//   single result. A completion that advances the mark takes the job, sweeps
//   the early-finished chunks from the bitmap, drains reached thresholds from
//   the threshold ring through its registered read port, and reports.
// Reset and stall:
//   reset clears the sequence counters, mark, bitmap and threshold ring and
//   sets the chunk size to 2^20 bytes. A stalled rsp_bus holds its result;
//   the queue keeps accepting request transfers until it fills.
module chunked_copy_completion_tracker_unit #(
   parameter int EARLY_WINDOW  = 64,
   parameter int REQUEST_DEPTH = 16,
   parameter int MAX_CHUNKS    = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ccct_pkg::LOG2_W-1:0]   csr_wr_data,
   ccct_req_if.sink                      req_bus,
   ccct_rsp_if.source                    rsp_bus
);
   import ccct_pkg::*;

   job_type  front_job;
   logic     front_valid;
   logic     front_ready;
   job_type  back_job;
   logic     back_valid;
   logic     back_ready;

   // classification front end
   ccct_front #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .job_data    (front_job),
      .job_valid   (front_valid),
      .job_ready   (front_ready)
   );

   // decoupling queue
   ccct_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_job),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (back_job),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   // execution back end
   ccct_back #(
      .EARLY_WINDOW  (EARLY_WINDOW),
      .REQUEST_DEPTH (REQUEST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (back_job),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> tb/sv/chunked_copy_completion_tracker_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the chunked copy completion tracker: copies, chunk
// completions and threshold requests with a predictor of mark, bitmap and ring
// depends on ccct_pkg, ccct_channels and chunked_copy_completion_tracker_unit
module chunked_copy_completion_tracker_unit_tb;
   import ccct_pkg::*;

   localparam int TRACK_WINDOW      = 64;
   localparam int RING_DEPTH        = 16;
   localparam int CHUNK_LIMIT       = 64;
   localparam int IDLE_PERCENT      = 15;
   localparam int SETTLE_CYCLES     = 16;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int RUN_LIMIT_NS      = 2_000_000;
   localparam int SMALL_CHUNK       = 1 << CHUNK_LOG2_MIN;
   localparam logic [TYPE_W-1:0] REQ_UNDEFINED = 2'd3;
   localparam logic [SEQ_W-1:0]  SEQ_TOP       = '1;

   typedef struct {
      logic [TYPE_W-1:0]  code;
      logic [ADDR_W-1:0]  source;
      logic [ADDR_W-1:0]  dest;
      logic [BYTES_W-1:0] bytes;
      logic [SEQ_W-1:0]   seq;
   } copy_op_type;

   typedef struct {
      result_kind_type   kind;
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] dest;
      logic [LEN_W-1:0]  length;
      logic [SEQ_W-1:0]  seq;
      logic              done;
      logic [SEQ_W-1:0]  mark;
      logic              last;
   } tracker_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [LOG2_W-1:0] csr_wr_data;

   ccct_req_if req_bus ();
   ccct_rsp_if rsp_bus ();

   chunked_copy_completion_tracker_unit #(
      .EARLY_WINDOW  (TRACK_WINDOW),
      .REQUEST_DEPTH (RING_DEPTH),
      .MAX_CHUNKS    (CHUNK_LIMIT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always #2 clock = ~clock;

   // predicted tracker state
   logic [LOG2_W-1:0]       model_log2;
   logic [SEQ_W-1:0]        model_next;
   logic [SEQ_W-1:0]        model_mark;
   logic [SEQ_W-1:0]        model_last_sig;
   logic [TRACK_WINDOW-1:0] model_early;
   logic [SEQ_W-1:0]        model_ring [RING_DEPTH];
   int                      model_head;
   int                      model_pending;

   // stimulus-side view of open chunk sequences
   logic [LOG2_W-1:0] gen_log2;
   logic [SEQ_W-1:0]  gen_next;
   logic [SEQ_W-1:0]  gen_open [$];

   copy_op_type        ops_to_send [$];
   tracker_result_type awaited_results [$];
   copy_op_type        offered_op;
   tracker_result_type head_result;

   int mismatches;
   int ops_accepted;
   int results_seen;
   int settings_written;
   int desc_seen, signal_seen, error_seen, answer_seen, ack_seen;
   int stall_count;
   bit stall_armed;
   bit steady_run;

   function automatic logic [LOG2_W-1:0] clamp_log2(logic [LOG2_W-1:0] v);
      if (v < CHUNK_LOG2_MIN) return CHUNK_LOG2_MIN;
      if (v > CHUNK_LOG2_MAX) return CHUNK_LOG2_MAX;
      return v;
   endfunction

   function automatic longint unsigned chunk_count(logic [BYTES_W-1:0] bytes,
                                                   logic [LOG2_W-1:0] lg);
      longint unsigned csize;
      csize = 64'd1 << lg;
      return ({33'd0, bytes} + csize - 1) >> lg;
   endfunction

   function automatic logic [ADDR_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   function automatic void post_result(result_kind_type kind, logic [ADDR_W-1:0] src,
                                       logic [ADDR_W-1:0] dst, logic [LEN_W-1:0] len,
                                       logic [SEQ_W-1:0] seq, logic done,
                                       logic [SEQ_W-1:0] mark, logic last);
      tracker_result_type r;
      r.kind   = kind;
      r.source = src;
      r.dest   = dst;
      r.length = len;
      r.seq    = seq;
      r.done   = done;
      r.mark   = mark;
      r.last   = last;
      awaited_results.insert(awaited_results.size(), r);
   endfunction

   function automatic void post_single(result_kind_type kind, logic done);
      post_result(kind, '0, '0, '0, '0, done, model_mark, 1'b1);
   endfunction

   // expected results of one accepted transfer, updates the predicted state
   task automatic track_op(copy_op_type op);
      logic [LOG2_W-1:0] lg;
      longint unsigned   csize, nch, off, left, i;
      logic [SEQ_W-1:0]  mark_gap;
      bit                drained;
      lg = clamp_log2(model_log2);
      case (op.code)
         REQ_ENQUEUE: begin
            nch = chunk_count(op.bytes, lg);
            if (nch == 0) begin
               post_single(RK_ACK, 1'b0);
            end else if (nch > CHUNK_LIMIT) begin
               post_single(RK_ERROR, 1'b0);
            end else begin
               csize = 64'd1 << lg;
               for (i = 0; i < nch; i++) begin
                  off  = i * csize;
                  left = op.bytes - off;
                  if (left > csize) left = csize;
                  post_result(RK_DESC, op.source + off[ADDR_W-1:0],
                              op.dest + off[ADDR_W-1:0], left[LEN_W-1:0],
                              model_next, 1'b0, '0, i == nch - 1);
                  model_next = model_next + 1'b1;
               end
            end
         end
         REQ_FINISH: begin
            mark_gap = op.seq - model_mark;
            if (mark_gap != 0) begin
               // early finish inside the window, anything else is rejected
               if (mark_gap >= TRACK_WINDOW) begin
                  post_single(RK_ERROR, 1'b0);
               end else begin
                  model_early[op.seq % TRACK_WINDOW] = 1'b1;
                  post_single(RK_ACK, 1'b0);
               end
            end else begin
               // advance the mark, sweep the bitmap, drain reached thresholds
               model_mark = model_mark + 1'b1;
               while (model_early[model_mark % TRACK_WINDOW]) begin
                  model_early[model_mark % TRACK_WINDOW] = 1'b0;
                  model_mark = model_mark + 1'b1;
               end
               drained = 1'b0;
               while (model_pending > 0 && model_ring[model_head] <= model_mark) begin
                  model_head    = (model_head + 1) % RING_DEPTH;
                  model_pending = model_pending - 1;
                  drained       = 1'b1;
               end
               if (drained && model_mark > model_last_sig) begin
                  model_last_sig = model_mark;
                  post_single(RK_SIGNAL, 1'b0);
               end else begin
                  post_single(RK_ACK, 1'b0);
               end
            end
         end
         REQ_WAIT: begin
            if (model_mark >= op.seq) begin
               post_single(RK_ANSWER, 1'b1);
            end else if (model_pending > 0 &&
                         model_ring[(model_head + model_pending - 1) % RING_DEPTH] >= op.seq) begin
               post_single(RK_ANSWER, 1'b0);
            end else if (model_pending >= RING_DEPTH) begin
               post_single(RK_ERROR, 1'b0);
            end else begin
               model_ring[(model_head + model_pending) % RING_DEPTH] = op.seq;
               model_pending = model_pending + 1;
               post_single(RK_ANSWER, 1'b0);
            end
         end
         default: begin
            post_single(RK_ERROR, 1'b0);
         end
      endcase
   endtask

   task automatic report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // queue one transfer and keep the open-sequence view in step
   task automatic queue_op(logic [TYPE_W-1:0] code, logic [ADDR_W-1:0] src,
                           logic [ADDR_W-1:0] dst, logic [BYTES_W-1:0] bytes,
                           logic [SEQ_W-1:0] seq);
      copy_op_type     op;
      longint unsigned nch;
      logic [SEQ_W-1:0] gap;
      int              hit;
      op.code   = code;
      op.source = src;
      op.dest   = dst;
      op.bytes  = bytes;
      op.seq    = seq;
      ops_to_send.insert(ops_to_send.size(), op);
      hit = -1;
      if (code == REQ_ENQUEUE) begin
         nch = chunk_count(bytes, clamp_log2(gen_log2));
         if (nch >= 1 && nch <= CHUNK_LIMIT) begin
            repeat (nch) begin
               gen_open.insert(gen_open.size(), gen_next);
               gen_next = gen_next + 1'b1;
            end
         end
      end else if (code == REQ_FINISH && gen_open.size() > 0) begin
         gap = seq - gen_open[0];
         if (gap < TRACK_WINDOW) begin
            foreach (gen_open[k]) if (gen_open[k] == seq) hit = k;
            if (hit >= 0) gen_open.delete(hit);
         end
      end
   endtask

   // mostly well-formed copy, finish and wait traffic with some noise
   task automatic queue_random_ops(int count, bit with_burst);
      int               n, r, s, idx, top;
      logic [SEQ_W-1:0] base, seq, gap;
      logic [63:0]      bytes;
      longint unsigned  csize;
      n = 0;
      while (n < count) begin
         r     = $urandom_range(99);
         base  = (gen_open.size() > 0) ? gen_open[0] : gen_next;
         csize = 64'd1 << clamp_log2(gen_log2);
         if ((with_burst && n == 0) || r < 3) begin
            // rising thresholds, enough to overflow the request ring
            for (int k = 0; k < 18; k++)
               queue_op(REQ_WAIT, rand48(), rand48(), 31'($urandom), base + 20 + 2 * k);
            n += 18;
         end else if (r < 34 || (gen_open.size() == 0 && r < 72)) begin
            s = $urandom_range(99);
            if (s < 70)
               bytes = $urandom_range(6, 1) * csize - $urandom_range(32'(csize - 1), 0);
            else if (s < 78)
               bytes = 0;
            else if (s < 88)
               bytes = $urandom_range(64, 33) * csize - $urandom_range(32'(csize - 1), 0);
            else if (s < 94)
               bytes = $urandom_range(70, 65) * csize - $urandom_range(32'(csize - 1), 0);
            else
               bytes = {32'd0, $urandom};
            queue_op(REQ_ENQUEUE, rand48(), rand48(), bytes[BYTES_W-1:0], rand48());
            n++;
         end else if (r < 72) begin
            // finish one of the oldest open chunks, in or out of order
            top = (gen_open.size() > 8) ? 7 : gen_open.size() - 1;
            idx = $urandom_range(top, 0);
            gap = gen_open[idx] - base;
            if (gap >= TRACK_WINDOW) idx = 0;
            queue_op(REQ_FINISH, rand48(), rand48(), 31'($urandom), gen_open[idx]);
            n++;
         end else if (r < 90) begin
            s = $urandom_range(99);
            if (s < 20)
               seq = (base > 3) ? base - $urandom_range(3, 0) : '0;
            else
               seq = base + $urandom_range(12, 1);
            queue_op(REQ_WAIT, rand48(), rand48(), 31'($urandom), seq);
            n++;
         end else if (r < 95) begin
            s = $urandom_range(2);
            if (s == 0)
               seq = rand48();
            else if (s == 1)
               seq = base - 1'b1;
            else
               seq = base + $urandom_range(80, 0);
            queue_op(REQ_FINISH, rand48(), rand48(), 31'($urandom), seq);
            n++;
         end else begin
            queue_op(REQ_UNDEFINED, rand48(), rand48(), 31'($urandom), rand48());
            n++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (ops_to_send.size() != 0 || req_bus.valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_chunk_log2(logic [LOG2_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_log2 = v;
      gen_log2   = v;
      settings_written++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_op(offered_op);
            ops_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (ops_to_send.size() > 0 &&
                (steady_run || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered_op = ops_to_send[0];
               ops_to_send.delete(0);
               req_bus.valid          <= 1'b1;
               req_bus.req_type       <= offered_op.code;
               req_bus.source_address <= offered_op.source;
               req_bus.dest_address   <= offered_op.dest;
               req_bus.copy_bytes     <= offered_op.bytes;
               req_bus.seq_number     <= offered_op.seq;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            case (rsp_bus.result_kind)
               RK_DESC:   desc_seen++;
               RK_ANSWER: answer_seen++;
               RK_SIGNAL: signal_seen++;
               RK_ACK:    ack_seen++;
               default:   error_seen++;
            endcase
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer of kind %0d",
                                         rsp_bus.result_kind));
            end else begin
               head_result = awaited_results[0];
               awaited_results.delete(0);
               check_field("result_kind", rsp_bus.result_kind, head_result.kind);
               check_field("chunk_source", rsp_bus.chunk_source, head_result.source);
               check_field("chunk_dest", rsp_bus.chunk_dest, head_result.dest);
               check_field("chunk_length", rsp_bus.chunk_length, head_result.length);
               check_field("chunk_seq", rsp_bus.chunk_seq, head_result.seq);
               check_field("already_done", rsp_bus.already_done, head_result.done);
               check_field("done_mark", rsp_bus.done_mark, head_result.mark);
               check_field("last_of_run", rsp_bus.last_of_run, head_result.last);
            end
         end
         // one long hold-off once armed, otherwise random back-pressure unless in a steady run
         if (stall_armed && stall_count < LONG_STALL_CYCLES) begin
            stall_count++;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("chunked_copy_completion_tracker_unit verification failed");
      $finish;
   end

   // stimulus sequence
   initial begin
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_bus.valid          = 1'b0;
      req_bus.req_type       = '0;
      req_bus.source_address = '0;
      req_bus.dest_address   = '0;
      req_bus.copy_bytes     = '0;
      req_bus.seq_number     = '0;
      rsp_bus.ready          = 1'b0;
      model_log2     = CHUNK_LOG2_RESET;
      model_next     = '0;
      model_mark     = '0;
      model_last_sig = '0;
      model_early    = '0;
      model_head     = 0;
      model_pending  = 0;
      gen_log2       = CHUNK_LOG2_RESET;
      gen_next       = '0;
      stall_armed    = 1'b0;
      steady_run     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // directed: copy sizes, window edges, threshold ring basics
      write_chunk_log2(CHUNK_LOG2_MIN);
      queue_op(REQ_ENQUEUE, '0, '0, '0, '0);
      queue_op(REQ_ENQUEUE, 48'hFFFF_FFFF_F000, SEQ_TOP, 31'(64 * SMALL_CHUNK), '0);
      queue_op(REQ_ENQUEUE, rand48(), rand48(), 31'(64 * SMALL_CHUNK + 1), '0);
      queue_op(REQ_ENQUEUE, '0, '0, 31'd5000, '0);
      queue_op(REQ_UNDEFINED, SEQ_TOP, SEQ_TOP, '1, SEQ_TOP);
      queue_op(REQ_WAIT, '0, '0, '0, '0);
      queue_op(REQ_FINISH, '0, '0, '0, SEQ_TOP);
      queue_op(REQ_FINISH, '0, '0, '0, 48'd64);
      queue_op(REQ_FINISH, '0, '0, '0, 48'd2);
      queue_op(REQ_FINISH, '0, '0, '0, 48'd2);
      queue_op(REQ_FINISH, '0, '0, '0, 48'd0);
      queue_op(REQ_WAIT, '0, '0, '0, 48'd3);
      queue_op(REQ_WAIT, '0, '0, '0, 48'd3);
      queue_op(REQ_FINISH, '0, '0, '0, 48'd1);
      queue_op(REQ_WAIT, '0, '0, '0, 48'd2);
      queue_random_ops(70, 1'b0);
      wait_drained();

      // largest chunks, full-size and oversized copies first
      write_chunk_log2(CHUNK_LOG2_MAX);
      queue_op(REQ_ENQUEUE, rand48(), rand48(), 31'h4000_0000, '0);
      queue_op(REQ_ENQUEUE, rand48(), rand48(), 31'h7FFF_FFFF, '0);
      queue_random_ops(72, 1'b1);
      wait_drained();

      // below range setting, with a long result hold-off
      write_chunk_log2(5'd0);
      stall_armed <= 1'b1;
      queue_random_ops(74, 1'b0);
      wait_drained();

      // above range setting, paused halfway until all results are back
      write_chunk_log2(5'd31);
      queue_random_ops(37, 1'b0);
      wait_drained();
      queue_random_ops(37, 1'b0);
      wait_drained();

      // no idling on either side
      write_chunk_log2(5'd17);
      steady_run = 1'b1;
      queue_random_ops(74, 1'b0);
      wait_drained();
      steady_run = 1'b0;

      // back to the reset setting, ending with top thresholds
      write_chunk_log2(CHUNK_LOG2_RESET);
      queue_random_ops(70, 1'b0);
      queue_op(REQ_WAIT, '0, '0, '0, SEQ_TOP);
      queue_op(REQ_WAIT, '0, '0, '0, 48'h8000_0000_0000);
      wait_drained();

      $display("covered %0d transfers over %0d chunk-size settings, %0d results checked",
               ops_accepted, settings_written, results_seen);
      $display("results: %0d descriptors, %0d answers, %0d signals, %0d acks, %0d errors",
               desc_seen, answer_seen, signal_seen, ack_seen, error_seen);
      if (mismatches == 0) begin
         $display("chunked_copy_completion_tracker_unit verification clean");
      end else begin
         $display("chunked_copy_completion_tracker_unit verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ccct_pkg.sv
hdl/ccct_channels.sv
hdl/ccct_front.sv
hdl/ccct_fifo.sv
hdl/ccct_back.sv
hdl/chunked_copy_completion_tracker_unit.sv
tb/sv/chunked_copy_completion_tracker_unit_tb.sv
